// File: hdl/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg
// Shared sizes, types and control words for the prime sieve filter chain.
// ----------------------------------------------------------------------------
package psf_pkg;

   localparam int NUM_CELLS  = 64;
   localparam int VALUE_BITS = 16;
   localparam int WORD_BITS  = 16;

   localparam int CNT_BITS   = $clog2(NUM_CELLS + 1);
   localparam int MAX_STEPS  = (VALUE_BITS > NUM_CELLS) ? VALUE_BITS : NUM_CELLS;
   localparam int STEP_BITS  = $clog2(MAX_STEPS + 1);

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [CNT_BITS-1:0]   count_type;
   typedef logic [STEP_BITS-1:0]  step_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCAN,
      ST_RESOLVE
   } state_type;

   // Control word broadcast from the sequencer to every cell.
   typedef struct packed {
      logic      start;
      logic      div_step;
      logic      cand_bit;
      logic      scan_step;
      logic      store;
      value_type store_value;
      count_type cells_used;
   } cell_ctrl_type;

endpackage

// File: hdl/psf_req_if.sv
// ----------------------------------------------------------------------------
// psf_req_if
// Candidate stream: valid/ready handshake with one candidate word.
// ----------------------------------------------------------------------------
interface psf_req_if;
   logic                               valid;
   logic                               ready;
   logic [psf_pkg::WORD_BITS-1:0]      candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

// File: hdl/psf_rsp_if.sv
// ----------------------------------------------------------------------------
// psf_rsp_if
// Result stream: valid/ready handshake with found prime and full flag.
// ----------------------------------------------------------------------------
interface psf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [psf_pkg::WORD_BITS-1:0]      found_prime;
   logic                               table_full;

   modport source (output valid, output found_prime, output table_full, input ready);
   modport sink   (input valid, input found_prime, input table_full, output ready);
endinterface

// File: hdl/psf_cell.sv
// ----------------------------------------------------------------------------
// psf_cell
// One filter cell: holds a stored prime, reduces the broadcast candidate
// modulo that prime one bit per cycle, and passes a divided flag along.
// ----------------------------------------------------------------------------
module psf_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  psf_pkg::count_type     cell_index,
   input  psf_pkg::cell_ctrl_type ctrl,
   input  logic                   flag_prev,
   output logic                   flag_next
);
   import psf_pkg::*;

   value_type             prime_ff;
   value_type             rem_ff, rem_in;
   logic                  flag_ff, flag_in;
   logic [VALUE_BITS:0]   shifted;
   logic                  occupied;
   logic                  hit;

   assign occupied = cell_index < ctrl.cells_used;
   assign hit      = occupied && (rem_ff == '0);

   // restoring remainder step
   always_comb begin
      shifted = {rem_ff, ctrl.cand_bit};
      if (shifted >= {1'b0, prime_ff}) begin
         shifted = shifted - {1'b0, prime_ff};
      end
      rem_in = rem_ff;
      if (ctrl.start) begin
         rem_in = '0;
      end else if (ctrl.div_step) begin
         rem_in = shifted[VALUE_BITS-1:0];
      end
   end

   always_comb begin
      flag_in = flag_ff;
      if (ctrl.start) begin
         flag_in = 1'b0;
      end else if (ctrl.scan_step) begin
         flag_in = flag_prev | hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (ctrl.store && (ctrl.cells_used == cell_index)) begin
         prime_ff <= ctrl.store_value;
      end
   end

   assign flag_next = flag_ff;

endmodule

// File: hdl/prime_sieve_filter_chain_unit.sv
// ----------------------------------------------------------------------------
// prime_sieve_filter_chain_unit
// Prime sieve over a chain of filter cells; survivors are emitted and stored while cells remain.
// ----------------------------------------------------------------------------
//  channel  dir  payload                    accepted when
//  req      in   candidate[15:0]            valid && ready
//  rsp      out  found_prime[15:0], full    valid && ready
//
//  The cells reduce a candidate one bit per cycle, then the divided flag
//  ripples down the chain one cell per cycle. A result waits in the output
//  register, so the next candidate is taken while it is pending; resolve
//  stalls only when a new survivor meets a still-full output register.
//  Reset clears the fill count and the sequencer; stored primes are read
//  only below the fill count.
// ----------------------------------------------------------------------------
module prime_sieve_filter_chain_unit (
   input  logic     clock,
   input  logic     reset,
   psf_req_if.sink  req_port,
   psf_rsp_if.source rsp_port
);
   import psf_pkg::*;

   state_type      state_ff, state_in;
   step_type       step_ff, step_in;
   value_type      value_ff;
   value_type      shift_ff;
   count_type      used_ff, used_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_prime_ff;
   logic           rsp_full_ff;
   cell_ctrl_type  ctrl;
   logic [NUM_CELLS:0] flag_chain;
   logic           accept;
   logic           dropped;
   logic           emit;
   logic           out_free;

   assign accept   = req_port.valid && req_port.ready;
   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign dropped  = flag_chain[NUM_CELLS] || (value_ff < VALUE_BITS'(2));

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(VALUE_BITS - 1)) begin
               step_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(NUM_CELLS - 1)) begin
               step_in  = '0;
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (dropped || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_port.ready = 1'b0;
      emit           = 1'b0;
      ctrl           = '0;
      unique case (state_ff)
         ST_IDLE:    req_port.ready = 1'b1;
         ST_DIVIDE:  ctrl.div_step  = 1'b1;
         ST_SCAN:    ctrl.scan_step = 1'b1;
         ST_RESOLVE: emit = !dropped && out_free;
         default:    emit = 1'b0;
      endcase
      ctrl.start       = accept;
      ctrl.cand_bit    = shift_ff[VALUE_BITS-1];
      ctrl.store       = emit && (used_ff < CNT_BITS'(NUM_CELLS));
      ctrl.store_value = value_ff;
      ctrl.cells_used  = used_ff;
   end

   always_comb begin
      used_in = used_ff;
      if (ctrl.store) begin
         used_in = used_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_ff <= VALUE_BITS'(req_port.candidate);
         shift_ff <= VALUE_BITS'(req_port.candidate);
      end else if (ctrl.div_step) begin
         shift_ff <= {shift_ff[VALUE_BITS-2:0], 1'b0};
      end
      if (emit) begin
         rsp_prime_ff <= WORD_BITS'(value_ff);
         rsp_full_ff  <= !ctrl.store;
      end
   end

   assign flag_chain[0] = 1'b0;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      psf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (CNT_BITS'(i)),
         .ctrl       (ctrl),
         .flag_prev  (flag_chain[i]),
         .flag_next  (flag_chain[i+1])
      );
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.found_prime = rsp_prime_ff;
   assign rsp_port.table_full  = rsp_full_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_BITS'(NUM_CELLS))
      else $error("fill count above cell count");

   a_store_counts: assert property (@(posedge clock) disable iff (reset)
      ctrl.store |=> used_ff == $past(used_ff) + 1'b1)
      else $error("stored prime did not advance fill count");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_port.table_full == ($past(used_ff) == CNT_BITS'(NUM_CELLS)))
      else $error("full flag does not match fill count");

   a_emit_survivor: assert property (@(posedge clock) disable iff (reset)
      emit |-> !flag_chain[NUM_CELLS] && value_ff >= VALUE_BITS'(2))
      else $error("emitted a divided or trivial candidate");

endmodule
